### rtl/core/bloom_filter_two_hash_assert.svh
// Assertion macros shared by the bloom filter RTL.
`ifndef BLOOM_FILTER_TWO_HASH_ASSERT_SVH
`define BLOOM_FILTER_TWO_HASH_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every aclk edge outside reset.
`define BFTH_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("bfth assertion failed");

// Checked on every aclk edge, reset included.
`define BFTH_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("bfth assertion failed");

`else

`define BFTH_ASSERT(label, prop)
`define BFTH_ASSERT_ALWAYS(label, prop)

`endif

`endif

### rtl/core/bfth_pkg.sv
// Shared constants, types, commands and hash function of the bloom filter.
package bfth_pkg;

    // Filter geometry; the entry count is a power of two, so the modulo is a mask
    localparam int FILTER_ENTRIES = 1048576;
    localparam int IDX_W          = $clog2(FILTER_ENTRIES);
    localparam int ROW_W          = 64;
    localparam int COL_W          = $clog2(ROW_W);
    localparam int ROW_AW         = IDX_W - COL_W;
    localparam int ROWS           = FILTER_ENTRIES / ROW_W;

    // Key and hash
    localparam int BYTE_W         = 8;
    localparam int KEY_BYTES      = 20;
    localparam int KEY_W          = KEY_BYTES * BYTE_W;
    localparam int BYTES_PER_STEP = 2;
    localparam int STEP_BITS      = BYTES_PER_STEP * BYTE_W;
    localparam int HASH_STEPS     = KEY_BYTES / BYTES_PER_STEP;
    localparam int STEP_W         = $clog2(HASH_STEPS);
    localparam int HASH_W         = 32;

    // Configuration port
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;

    typedef logic [HASH_W-1:0]     hash_t;
    typedef logic [KEY_W-1:0]      key_t;
    typedef logic [ROW_W-1:0]      row_t;
    typedef logic [ROW_AW-1:0]     row_addr_t;
    typedef logic [COL_W-1:0]      col_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [STEP_W-1:0]     step_cnt_t;
    typedef logic [BYTE_W-1:0]     byte_t;

    localparam hash_t HASH_MUL          = 32'd31;
    localparam hash_t HASH_MUL_SQ       = HASH_MUL * HASH_MUL;
    localparam hash_t SEED_FIRST_RESET  = 32'h1234_5678;
    localparam hash_t SEED_SECOND_RESET = 32'h8765_4321;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED_FIRST  = 2'd0,
        CFG_SEED_SECOND = 2'd1
    } cfg_idx_t;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_QUERY  = 1'b1
    } func_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_WR_A,
        ST_WR_B,
        ST_RD_A,
        ST_RD_B,
        ST_CHK,
        ST_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_key;
        logic hash_step;
        logic clr_row;
        logic wr_a;
        logic wr_b;
        logic rd_b;
        logic cap_a;
        logic cap_hit;
        logic out_load;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic hash_last;
        logic is_query;
        logic out_busy;
    } dp_status_t;

    // Two hash rounds at once: h*31*31 + b0*31 + b1, wrapping at 32 bits
    function automatic hash_t hash_pair(hash_t h, byte_t b0, byte_t b1);
        return h * HASH_MUL_SQ + hash_t'(b0) * HASH_MUL + hash_t'(b1);
    endfunction

endpackage

### rtl/core/bloom_filter_two_hash.sv
// Top level of the two-probe bloom filter over 20-byte keys.
// An insert hashes the key, then sets probe bit A and then bit B; a query hashes
// the key, reads rows A and B, checks both bits and loads the result register,
// waiting while an earlier result is unaccepted; m_valid rises as s_ready returns.
// Two hash units take two key bytes per cycle; the bit memory has one write port and
// one registered read port, two accesses per item. Reset: seeds return to defaults,
// then a clearing pass zeroes the memory one 64-bit row per cycle with s_ready low.
module bloom_filter_two_hash (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic [63:0]                       s_key_head,
    input  logic [63:0]                       s_key_middle,
    input  logic [31:0]                       s_key_tail,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_maybe_present,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfth_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfth_pkg::CFG_DATA_W-1:0]   cfg_data
);

    bfth_pkg::ctrl_cmd_t  cmd;
    bfth_pkg::dp_status_t status;

    // Sequencer
    bfth_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hashing, bit memory and result register
    bfth_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_func          (s_func),
        .s_key_head      (s_key_head),
        .s_key_middle    (s_key_middle),
        .s_key_tail      (s_key_tail),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_maybe_present (m_maybe_present),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

### rtl/core/bfth_ctrl.sv
// Controller state machine: sequences clearing, hashing and bit accesses.
`include "bloom_filter_two_hash_assert.svh"

module bfth_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  bfth_pkg::dp_status_t    status,
    output bfth_pkg::ctrl_cmd_t     cmd
);

    bfth_pkg::state_t state_reg;
    bfth_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfth_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            bfth_pkg::ST_CLEAR: begin
                cmd.clr_row = 1'b1;
                if (status.clr_last) begin
                    state_next = bfth_pkg::ST_IDLE;
                end
            end
            bfth_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_key = 1'b1;
                    state_next   = bfth_pkg::ST_HASH;
                end
            end
            bfth_pkg::ST_HASH: begin
                cmd.hash_step = 1'b1;
                if (status.hash_last) begin
                    state_next = status.is_query ? bfth_pkg::ST_RD_A : bfth_pkg::ST_WR_A;
                end
            end
            bfth_pkg::ST_WR_A: begin
                cmd.wr_a   = 1'b1;
                state_next = bfth_pkg::ST_WR_B;
            end
            bfth_pkg::ST_WR_B: begin
                cmd.wr_b   = 1'b1;
                state_next = bfth_pkg::ST_IDLE;
            end
            // row A is read by default address selection
            bfth_pkg::ST_RD_A: begin
                state_next = bfth_pkg::ST_RD_B;
            end
            bfth_pkg::ST_RD_B: begin
                cmd.rd_b   = 1'b1;
                cmd.cap_a  = 1'b1;
                state_next = bfth_pkg::ST_CHK;
            end
            bfth_pkg::ST_CHK: begin
                cmd.rd_b    = 1'b1;
                cmd.cap_hit = 1'b1;
                state_next  = bfth_pkg::ST_RESULT;
            end
            bfth_pkg::ST_RESULT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = bfth_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bfth_pkg::ST_IDLE;
            end
        endcase
    end

    // Only one memory write per cycle
    `BFTH_ASSERT(a_one_write, $onehot0({cmd.clr_row, cmd.wr_a, cmd.wr_b}))
    // A result is never loaded over one that is still waiting
    `BFTH_ASSERT(a_no_overwrite, cmd.out_load |-> !status.out_busy)
    // Hashing ends in a memory read or memory write state
    `BFTH_ASSERT(a_hash_exit, (cmd.hash_step && status.hash_last) |=>
        ((state_reg == bfth_pkg::ST_RD_A) || (state_reg == bfth_pkg::ST_WR_A)))

endmodule

### rtl/core/bfth_dp.sv
// Datapath: seeds, key shifter, two hash units, bit memory and result register.
`include "bloom_filter_two_hash_assert.svh"

module bfth_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_func,
    input  logic [63:0]                       s_key_head,
    input  logic [63:0]                       s_key_middle,
    input  logic [31:0]                       s_key_tail,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_maybe_present,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfth_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfth_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  bfth_pkg::ctrl_cmd_t               cmd,
    output bfth_pkg::dp_status_t              status
);

    bfth_pkg::hash_t     seed_first_reg;
    bfth_pkg::hash_t     seed_second_reg;
    bfth_pkg::key_t      key_reg;
    bfth_pkg::hash_t     hash_a_reg;
    bfth_pkg::hash_t     hash_b_reg;
    bfth_pkg::step_cnt_t step_cnt_reg;
    bfth_pkg::row_addr_t clr_row_reg;
    logic                func_reg;
    bfth_pkg::row_t      rd_data_reg;
    logic                bit_a_reg;
    logic                hit_reg;
    logic                m_valid_reg;
    logic                m_maybe_present_reg;

    bfth_pkg::row_t      mem [bfth_pkg::ROWS];

    bfth_pkg::idx_t      idx_a;
    bfth_pkg::idx_t      idx_b;
    bfth_pkg::row_addr_t row_a;
    bfth_pkg::row_addr_t row_b;
    bfth_pkg::col_t      col_a;
    bfth_pkg::col_t      col_b;
    bfth_pkg::row_addr_t rd_row;
    bfth_pkg::byte_t     byte_hi;
    bfth_pkg::byte_t     byte_lo;

    assign cfg_ready = 1'b1;

    // Probe indices: low bits of the hash
    assign idx_a  = hash_a_reg[bfth_pkg::IDX_W-1:0];
    assign idx_b  = hash_b_reg[bfth_pkg::IDX_W-1:0];
    assign row_a  = idx_a[bfth_pkg::IDX_W-1:bfth_pkg::COL_W];
    assign row_b  = idx_b[bfth_pkg::IDX_W-1:bfth_pkg::COL_W];
    assign col_a  = idx_a[bfth_pkg::COL_W-1:0];
    assign col_b  = idx_b[bfth_pkg::COL_W-1:0];
    assign rd_row = cmd.rd_b ? row_b : row_a;

    // Next two key bytes, oldest first
    assign byte_hi = key_reg[bfth_pkg::KEY_W-1 -: bfth_pkg::BYTE_W];
    assign byte_lo = key_reg[bfth_pkg::KEY_W-1-bfth_pkg::BYTE_W -: bfth_pkg::BYTE_W];

    // Seed registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_first_reg  <= bfth_pkg::SEED_FIRST_RESET;
            seed_second_reg <= bfth_pkg::SEED_SECOND_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bfth_pkg::CFG_SEED_FIRST:  seed_first_reg  <= cfg_data;
                bfth_pkg::CFG_SEED_SECOND: seed_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control counters and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_cnt_reg <= '0;
            clr_row_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load_key) begin
                step_cnt_reg <= '0;
            end else if (cmd.hash_step) begin
                step_cnt_reg <= step_cnt_reg + bfth_pkg::step_cnt_t'(1);
            end
            if (cmd.clr_row) begin
                clr_row_reg <= clr_row_reg + bfth_pkg::row_addr_t'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Key shifter and the two hash units, two bytes per cycle
    always_ff @(posedge aclk) begin
        if (cmd.load_key) begin
            key_reg    <= {s_key_head, s_key_middle, s_key_tail};
            func_reg   <= s_func;
            hash_a_reg <= seed_first_reg;
            hash_b_reg <= seed_second_reg;
        end else if (cmd.hash_step) begin
            key_reg    <= key_reg << bfth_pkg::STEP_BITS;
            hash_a_reg <= bfth_pkg::hash_pair(hash_a_reg, byte_hi, byte_lo);
            hash_b_reg <= bfth_pkg::hash_pair(hash_b_reg, byte_hi, byte_lo);
        end
    end

    // Bit memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.clr_row) begin
            mem[clr_row_reg] <= '0;
        end else if (cmd.wr_a) begin
            mem[row_a][col_a] <= 1'b1;
        end else if (cmd.wr_b) begin
            mem[row_b][col_b] <= 1'b1;
        end
        rd_data_reg <= mem[rd_row];
    end

    // Probe bits and result payload
    always_ff @(posedge aclk) begin
        if (cmd.cap_a) begin
            bit_a_reg <= rd_data_reg[col_a];
        end
        if (cmd.cap_hit) begin
            hit_reg <= bit_a_reg & rd_data_reg[col_b];
        end
        if (cmd.out_load) begin
            m_maybe_present_reg <= hit_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_maybe_present = m_maybe_present_reg;

    // Status back to the controller
    always_comb begin
        status.clr_last  = (clr_row_reg == '1);
        status.hash_last = (step_cnt_reg == bfth_pkg::step_cnt_t'(bfth_pkg::HASH_STEPS - 1));
        status.is_query  = (func_reg == bfth_pkg::FUNC_QUERY);
        status.out_busy  = m_valid_reg & ~m_ready;
    end

    // Every item starts hashing from the first byte pair
    `BFTH_ASSERT(a_step_restart, cmd.load_key |=> (step_cnt_reg == '0))
    // A loaded result is offered on the next cycle
    `BFTH_ASSERT(a_out_shown, cmd.out_load |=> m_valid_reg)
    // The clearing pass wraps its row counter back to zero
    `BFTH_ASSERT(a_clr_wrap, (cmd.clr_row && status.clr_last) |=> (clr_row_reg == '0))

endmodule

### verif/tb_bloom_filter_two_hash.sv
// Self-checking testbench for the two-probe bloom filter: in-order membership prediction.
module tb_bloom_filter_two_hash;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 210;
    localparam int RECENT_KEYS   = 128;
    localparam bfth_pkg::hash_t KEY_MUL = 32'd31;

    // Register indexes that decode to nothing; writes there must be dropped
    localparam logic [bfth_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [bfth_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam bfth_pkg::key_t KEY_ZERO = '0;
    localparam bfth_pkg::key_t KEY_ONES = '1;
    localparam bfth_pkg::key_t KEY_AA   = {bfth_pkg::KEY_BYTES{8'hAA}};
    localparam bfth_pkg::key_t KEY_55   = {bfth_pkg::KEY_BYTES{8'h55}};
    localparam bfth_pkg::key_t KEY_LSB  = bfth_pkg::key_t'(1);

    logic                            aclk            = 1'b0;
    logic                            aresetn         = 1'b0;
    logic                            s_valid         = 1'b0;
    logic                            s_ready;
    logic                            s_func          = 1'b0;
    logic [63:0]                     s_key_head      = '0;
    logic [63:0]                     s_key_middle    = '0;
    logic [31:0]                     s_key_tail      = '0;
    logic                            m_valid;
    logic                            m_ready         = 1'b0;
    logic                            m_maybe_present;
    logic                            cfg_valid       = 1'b0;
    logic                            cfg_ready;
    logic [bfth_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [bfth_pkg::CFG_DATA_W-1:0] cfg_data        = '0;

    // Shadow of the filter contents and seeds
    bit              filter_shadow [bfth_pkg::FILTER_ENTRIES];
    bfth_pkg::hash_t seed_first_shadow  = bfth_pkg::SEED_FIRST_RESET;
    bfth_pkg::hash_t seed_second_shadow = bfth_pkg::SEED_SECOND_RESET;

    bit              presence_expected [$];
    bfth_pkg::key_t  inserted_keys [$];

    int    error_count     = 0;
    int    cycle_count     = 0;
    int    sink_stall_left = 0;
    bit    src_idle_en     = 1'b1;
    bit    sink_idle_en    = 1'b1;

    bloom_filter_two_hash u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_key_head      (s_key_head),
        .s_key_middle    (s_key_middle),
        .s_key_tail      (s_key_tail),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_maybe_present (m_maybe_present),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side back-pressure: m_ready dropped in random bursts while sink idling is enabled
    always @(posedge aclk) begin
        if (sink_stall_left != 0) begin
            sink_stall_left <= sink_stall_left - 1;
            m_ready         <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            sink_stall_left <= $urandom_range(0, 6);
            m_ready         <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare every accepted result with the oldest pending query answer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (presence_expected.size() == 0) begin
                $error("maybe_present: expected no item, got %0b", m_maybe_present);
                error_count++;
            end else if (m_maybe_present !== presence_expected[0]) begin
                $error("maybe_present: expected %0b, got %0b",
                       presence_expected[0], m_maybe_present);
                error_count++;
                void'(presence_expected.pop_front());
            end else begin
                void'(presence_expected.pop_front());
            end
        end
    end

    // Probe slot: seeded multiply-by-31 byte hash, reduced modulo the filter size
    function automatic bfth_pkg::idx_t probe_slot(bfth_pkg::hash_t seed, bfth_pkg::key_t key);
        bfth_pkg::hash_t acc;
        int              i;
        acc = seed;
        for (i = 0; i < bfth_pkg::KEY_BYTES; i++)
            acc = acc * KEY_MUL + bfth_pkg::hash_t'(key[bfth_pkg::KEY_W-1-8*i -: 8]);
        return bfth_pkg::idx_t'(acc % bfth_pkg::hash_t'(bfth_pkg::FILTER_ENTRIES));
    endfunction

    function automatic bfth_pkg::key_t random_key();
        return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Offer one item; valid stays high afterwards until the next gap or drain
    task automatic send_item(bfth_pkg::func_t func, bfth_pkg::key_t key);
        bfth_pkg::idx_t slot_a;
        bfth_pkg::idx_t slot_b;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= func;
        s_key_head   <= key[159:96];
        s_key_middle <= key[95:32];
        s_key_tail   <= key[31:0];
        do @(posedge aclk); while (!s_ready);

        // Item accepted at this edge: update the shadow in order
        slot_a = probe_slot(seed_first_shadow, key);
        slot_b = probe_slot(seed_second_shadow, key);
        if (func == bfth_pkg::FUNC_INSERT) begin
            filter_shadow[slot_a] = 1'b1;
            filter_shadow[slot_b] = 1'b1;
            inserted_keys.push_back(key);
            if (inserted_keys.size() > RECENT_KEYS)
                void'(inserted_keys.pop_front());
        end else begin
            presence_expected.push_back(filter_shadow[slot_a] && filter_shadow[slot_b]);
        end
    endtask

    // Register write; valid stays high so back-to-back writes need no gap
    task automatic write_reg(logic [bfth_pkg::CFG_IDX_W-1:0] index, bfth_pkg::hash_t data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            bfth_pkg::CFG_SEED_FIRST:  seed_first_shadow  = data;
            bfth_pkg::CFG_SEED_SECOND: seed_second_shadow = data;
            default: ;
        endcase
    endtask

    // Block goes idle: input released, all answers in, inserts allowed to finish
    task automatic drain();
        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        while (presence_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Default seeds, empty filter, extreme keys
    task automatic test_reset_seeds();
        send_item(bfth_pkg::FUNC_QUERY,  KEY_ZERO);
        send_item(bfth_pkg::FUNC_INSERT, KEY_ZERO);
        send_item(bfth_pkg::FUNC_QUERY,  KEY_ZERO);
        send_item(bfth_pkg::FUNC_INSERT, KEY_ONES);
        send_item(bfth_pkg::FUNC_QUERY,  KEY_ONES);
        send_item(bfth_pkg::FUNC_QUERY,  KEY_LSB);
        send_item(bfth_pkg::FUNC_INSERT, KEY_AA);
        send_item(bfth_pkg::FUNC_QUERY,  KEY_55);
        drain();
    endtask

    // Seeds at their extremes; writes to undecoded indexes must not land
    task automatic test_seed_extremes();
        write_reg(bfth_pkg::CFG_SEED_FIRST,  32'h0000_0000);
        write_reg(bfth_pkg::CFG_SEED_SECOND, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_A,               $urandom);
        write_reg(CFG_SPARE_B,               $urandom);
        drain();
        send_item(bfth_pkg::FUNC_QUERY,  KEY_ZERO);
        send_item(bfth_pkg::FUNC_INSERT, KEY_ONES);
        send_item(bfth_pkg::FUNC_QUERY,  KEY_ONES);
        send_item(bfth_pkg::FUNC_QUERY,  KEY_AA);
        send_item(bfth_pkg::FUNC_QUERY,  KEY_LSB);
        drain();
    endtask

    // Seeds equal modulo the filter size: both probes land on one slot
    task automatic test_equal_probes();
        bfth_pkg::hash_t seed;
        bfth_pkg::key_t  key;
        seed = $urandom;
        key  = random_key();
        write_reg(bfth_pkg::CFG_SEED_FIRST,  seed);
        write_reg(bfth_pkg::CFG_SEED_SECOND, seed);
        drain();
        send_item(bfth_pkg::FUNC_QUERY,  key);
        send_item(bfth_pkg::FUNC_INSERT, key);
        send_item(bfth_pkg::FUNC_QUERY,  key);
        drain();
        // Differ only above the index bits: still one shared slot
        write_reg(bfth_pkg::CFG_SEED_SECOND, seed ^ 32'hFFF0_0000);
        drain();
        key = random_key();
        send_item(bfth_pkg::FUNC_INSERT, key);
        send_item(bfth_pkg::FUNC_QUERY,  key);
        drain();
    endtask

    // Insert/query traffic: hits on stored keys, near misses and random probes
    task automatic test_random_traffic(bfth_pkg::hash_t seed_a, bfth_pkg::hash_t seed_b,
                                       bit with_idle);
        int             n;
        int             pick;
        bfth_pkg::key_t key;
        src_idle_en  = with_idle;
        sink_idle_en = with_idle;
        write_reg(bfth_pkg::CFG_SEED_FIRST,  seed_a);
        write_reg(bfth_pkg::CFG_SEED_SECOND, seed_b);
        drain();
        inserted_keys.delete();
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 || inserted_keys.size() == 0) begin
                send_item(bfth_pkg::FUNC_INSERT, random_key());
            end else begin
                key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
                if (pick >= 85)
                    key = random_key();
                else if (pick >= 70)
                    key = key ^ (KEY_LSB << $urandom_range(0, bfth_pkg::KEY_W - 1));
                send_item(bfth_pkg::FUNC_QUERY, key);
            end
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_seeds();
        test_seed_extremes();
        test_equal_probes();
        test_random_traffic(bfth_pkg::SEED_FIRST_RESET, bfth_pkg::SEED_SECOND_RESET, 1'b1);
        test_random_traffic($urandom, $urandom, 1'b1);
        test_random_traffic(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        test_random_traffic($urandom, $urandom, 1'b0);

        if (presence_expected.size() != 0) begin
            $error("maybe_present: %0d expected items never arrived",
                   presence_expected.size());
            error_count++;
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
